// ===== design/topological_sort_kahn_macros.svh =====
// Assertion macros shared by the checker of the topological sorter.
`ifndef TOPOLOGICAL_SORT_KAHN_MACROS_SVH
`define TOPOLOGICAL_SORT_KAHN_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tsk_pkg.sv =====
// Package of shared constants for the topological sorter.
`timescale 1ns / 1ps
package tsk_pkg;

  // Node index and node count widths are fixed by the payload.
  localparam int NODE_W = 6;
  localparam int NCNT_W = 7;

  // Defaults for the top-level parameters.
  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  // Reset value of the node count register.
  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // Command codes.
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CYCLE = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

endpackage

// ===== design/tsk_if.sv =====
// Channel interfaces of the topological sorter: edge/command input and result output.
`timescale 1ns / 1ps
interface tsk_in_if;
  import tsk_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [NODE_W-1:0] edge_from;
  logic [NODE_W-1:0] edge_to;
  modport source (output valid, command, edge_from, edge_to, input ready);
  modport sink   (input valid, command, edge_from, edge_to, output ready);
endinterface

interface tsk_out_if;
  import tsk_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_index;
  logic              last_of_run;
  logic [1:0]        status;
  modport source (output valid, node_index, last_of_run, status, input ready);
  modport sink   (input valid, node_index, last_of_run, status, output ready);
endinterface

// ===== design/tsk_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module tsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/topological_sort_kahn.sv =====
// Top level of the topological sorter: edge loading, sort sequencer and result register.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------
//  in_ch   | in  | command, edge_from, edge_to
//  out_ch  | out | node_index, last_of_run, status
//  cfg_*   | in  | node_count (write only)
//
// An edge load is stored as it is accepted, so loads may arrive every cycle while idle.
// A run clears MAX_NODES in-degree counts, counts in-degrees over the stored edges,
// seeds the queue, walks the edges for each dequeued node and emits the order as
// result beats; the edge, in-degree and queue memories each have a registered read port.
// Reset (rst_n low, synchronous) empties the edge store and sets node_count to 64.
// A stalled result beat holds the sequencer; new input is taken once the run is done.
`timescale 1ns / 1ps
module topological_sort_kahn #(
  parameter int MAX_NODES = tsk_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = tsk_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tsk_in_if.sink                    in_ch,
  tsk_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tsk_pkg::NCNT_W-1:0] cfg_wdata
);
  import tsk_pkg::*;

  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int NA_W  = $clog2(MAX_NODES);
  localparam int NC_W  = $clog2(MAX_NODES + 1);
  localparam int DEG_W = EC_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_ERD  = 4'd2;
  localparam logic [3:0] S_EWT  = 4'd3;
  localparam logic [3:0] S_DWT  = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SWT  = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QWT  = 4'd8;
  localparam logic [3:0] S_ORD  = 4'd9;
  localparam logic [3:0] S_OWT  = 4'd10;
  localparam logic [3:0] S_FAIL = 4'd11;

  // Edge walk phases.
  localparam logic PH_COUNT = 1'b0;
  localparam logic PH_PROC  = 1'b1;

  logic [3:0]        state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [NCNT_W-1:0] ncnt_r, ncnt_nxt;
  logic [EC_W-1:0]   loaded_r, loaded_nxt;
  logic              drop_r, drop_nxt;
  logic              bad_r, bad_nxt;
  logic [EC_W-1:0]   e_r, e_nxt;
  logic [NC_W-1:0]   i_r, i_nxt;
  logic [NC_W-1:0]   head_r, head_nxt;
  logic [NC_W-1:0]   tail_r, tail_nxt;
  logic [NODE_W-1:0] u_r, u_nxt;
  logic [1:0]        fail_st_r, fail_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic              out_last_r, out_last_nxt;
  logic [1:0]        out_st_r, out_st_nxt;

  logic [NCNT_W-1:0] n_use;
  logic              in_acc, out_free, edge_ok;

  // Memory ports.
  logic                 e_we, e_re;
  logic [2*NODE_W-1:0]  e_rdata;
  logic [NODE_W-1:0]    e_src, e_tgt;
  logic                 d_we, d_re;
  logic [NA_W-1:0]      d_waddr, d_raddr;
  logic [DEG_W-1:0]     d_wdata, d_rdata;
  logic                 q_we, q_re;
  logic [NA_W-1:0]      q_waddr, q_raddr;
  logic [NODE_W-1:0]    q_wdata, q_rdata;

  // Effective node count: zero acts as one, above MAX_NODES is clamped.
  always_comb begin
    if (ncnt_r == '0) begin
      n_use = NCNT_W'(1);
    end else if (ncnt_r > NCNT_W'(MAX_NODES)) begin
      n_use = NCNT_W'(MAX_NODES);
    end else begin
      n_use = ncnt_r;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign edge_ok     = (NCNT_W'(in_ch.edge_from) < n_use) && (NCNT_W'(in_ch.edge_to) < n_use)
                       && (loaded_r < EC_W'(MAX_EDGES));
  assign e_src       = e_rdata[2*NODE_W-1:NODE_W];
  assign e_tgt       = e_rdata[NODE_W-1:0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.node_index  = out_node_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.status      = out_st_r;

  // Edge store: {source, target} per entry, in insertion order.
  tsk_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (loaded_r[EA_W-1:0]),
    .wdata ({in_ch.edge_from, in_ch.edge_to}),
    .re    (e_re),
    .raddr (e_r[EA_W-1:0]),
    .rdata (e_rdata)
  );

  // In-degree counts, one per node.
  tsk_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // Order queue; it also holds the final order for the emit pass.
  tsk_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Sequencer and memory control.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ncnt_nxt      = cfg_we ? cfg_wdata : ncnt_r;
    loaded_nxt    = loaded_r;
    drop_nxt      = drop_r;
    bad_nxt       = bad_r;
    e_nxt         = e_r;
    i_nxt         = i_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    u_nxt         = u_r;
    fail_st_nxt   = fail_st_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    e_we          = 1'b0;
    e_re          = 1'b0;
    d_we          = 1'b0;
    d_re          = 1'b0;
    d_waddr       = e_tgt[NA_W-1:0];
    d_raddr       = e_tgt[NA_W-1:0];
    d_wdata       = '0;
    q_we          = 1'b0;
    q_re          = 1'b0;
    q_waddr       = tail_r[NA_W-1:0];
    q_raddr       = head_r[NA_W-1:0];
    q_wdata       = e_tgt;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_ADD) begin
            if (edge_ok) begin
              e_we       = 1'b1;
              loaded_nxt = loaded_r + EC_W'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (drop_r) begin
            fail_st_nxt = ST_DROP;
            state_nxt   = S_FAIL;
          end else begin
            i_nxt     = '0;
            state_nxt = S_CLR;
          end
        end
      end
      // Zero every in-degree count, one entry a cycle.
      S_CLR: begin
        d_we    = 1'b1;
        d_waddr = i_r[NA_W-1:0];
        d_wdata = '0;
        i_nxt   = i_r + NC_W'(1);
        if (i_r == NC_W'(MAX_NODES - 1)) begin
          e_nxt     = '0;
          bad_nxt   = 1'b0;
          phase_nxt = PH_COUNT;
          state_nxt = S_ERD;
        end
      end
      // Issue the next edge read, or finish the walk.
      S_ERD: begin
        if (e_r == loaded_r) begin
          if (phase_r == PH_PROC) begin
            state_nxt = S_QRD;
          end else if (bad_r) begin
            fail_st_nxt = ST_DROP;
            state_nxt   = S_FAIL;
          end else begin
            i_nxt     = '0;
            head_nxt  = '0;
            tail_nxt  = '0;
            state_nxt = S_SRD;
          end
        end else begin
          e_re      = 1'b1;
          state_nxt = S_EWT;
        end
      end
      // Edge data ready: check it and fetch the target's count when needed.
      S_EWT: begin
        if (phase_r == PH_COUNT) begin
          if ((NCNT_W'(e_src) >= n_use) || (NCNT_W'(e_tgt) >= n_use)) begin
            bad_nxt = 1'b1;
          end
          d_re      = 1'b1;
          state_nxt = S_DWT;
        end else if (e_src == u_r) begin
          d_re      = 1'b1;
          state_nxt = S_DWT;
        end else begin
          e_nxt     = e_r + EC_W'(1);
          state_nxt = S_ERD;
        end
      end
      // Count ready: write it back, queueing the target when it drops to zero.
      S_DWT: begin
        if (phase_r == PH_COUNT) begin
          d_we    = 1'b1;
          d_wdata = d_rdata + DEG_W'(1);
        end else if (d_rdata != '0) begin
          d_we    = 1'b1;
          d_wdata = d_rdata - DEG_W'(1);
          if (d_rdata == DEG_W'(1)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + NC_W'(1);
          end
        end
        e_nxt     = e_r + EC_W'(1);
        state_nxt = S_ERD;
      end
      // Seed the queue with the nodes of in-degree zero, in index order.
      S_SRD: begin
        if (NCNT_W'(i_r) == n_use) begin
          state_nxt = S_QRD;
        end else begin
          d_re      = 1'b1;
          d_raddr   = i_r[NA_W-1:0];
          state_nxt = S_SWT;
        end
      end
      S_SWT: begin
        if (d_rdata == '0) begin
          q_we     = 1'b1;
          q_wdata  = NODE_W'(i_r);
          tail_nxt = tail_r + NC_W'(1);
        end
        i_nxt     = i_r + NC_W'(1);
        state_nxt = S_SRD;
      end
      // Dequeue the next node, or decide the outcome once the queue is empty.
      S_QRD: begin
        if (head_r == tail_r) begin
          if (NCNT_W'(tail_r) != n_use) begin
            fail_st_nxt = ST_CYCLE;
            state_nxt   = S_FAIL;
          end else begin
            i_nxt     = '0;
            state_nxt = S_ORD;
          end
        end else begin
          q_re      = 1'b1;
          head_nxt  = head_r + NC_W'(1);
          state_nxt = S_QWT;
        end
      end
      S_QWT: begin
        u_nxt     = q_rdata;
        e_nxt     = '0;
        phase_nxt = PH_PROC;
        state_nxt = S_ERD;
      end
      // Emit the order, one beat per node.
      S_ORD: begin
        if (NCNT_W'(i_r) == n_use) begin
          loaded_nxt = '0;
          drop_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end else begin
          q_re      = 1'b1;
          q_raddr   = i_r[NA_W-1:0];
          state_nxt = S_OWT;
        end
      end
      S_OWT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = q_rdata;
          out_last_nxt  = (NCNT_W'(i_r) + NCNT_W'(1) == n_use);
          out_st_nxt    = ST_OK;
          i_nxt         = i_r + NC_W'(1);
          state_nxt     = S_ORD;
        end
      end
      // Single status beat for a dropped edge or a cycle.
      S_FAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_st_nxt    = fail_st_r;
          loaded_nxt    = '0;
          drop_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_COUNT;
      ncnt_r      <= NODE_COUNT_RST;
      loaded_r    <= '0;
      drop_r      <= 1'b0;
      bad_r       <= 1'b0;
      e_r         <= '0;
      i_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fail_st_r   <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ncnt_r      <= ncnt_nxt;
      loaded_r    <= loaded_nxt;
      drop_r      <= drop_nxt;
      bad_r       <= bad_nxt;
      e_r         <= e_nxt;
      i_r         <= i_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fail_st_r   <= fail_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end
endmodule

// ===== design/tsk_checker.sv =====
// Port-level checker for the topological sorter, with its bind statement.
`timescale 1ns / 1ps
`include "topological_sort_kahn_macros.svh"
module tsk_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_command,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tsk_pkg::NODE_W-1:0] out_node_index,
  input logic                      out_last_of_run,
  input logic [1:0]                out_status
);
  import tsk_pkg::*;

  // A stalled result beat keeps its payload.
  `TSK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_node_index) && $stable(out_last_of_run) && $stable(out_status), "result beat changed while stalled")

  // A failure status is a lone beat with node index zero.
  `TSK_ASSERT_NOW(a_fail_form, out_valid && (out_status != ST_OK), (out_node_index == '0) && out_last_of_run, "malformed failure beat")

  // Status carries only defined codes.
  `TSK_ASSERT_NOW(a_status_code, out_valid, (out_status == ST_OK) || (out_status == ST_CYCLE) || (out_status == ST_DROP), "undefined status code")

  // A run command closes the input until the run is over.
  `TSK_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (in_command == CMD_RUN), !in_ready, "input open straight after a run command")
endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_node_index  (out_ch.node_index),
  .out_last_of_run (out_ch.last_of_run),
  .out_status      (out_ch.status)
);
